// ===== src/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, character constants and the digit encoder for the
// integer to ascii radix core.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int CHUNK_BITS = 8;

   localparam logic [6:0] CHAR_ZERO    = 7'h30;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_MINUS   = 7'h2d;

   localparam logic [5:0] RADIX_MIN = 6'd2;
   localparam logic [5:0] RADIX_MAX = 6'd36;
   localparam logic [5:0] RADIX_DEC = 6'd10;
   localparam logic [5:0] DIGIT_MAX = 6'd9;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIVIDE = 6'b000010,
      ST_STORE  = 6'b000100,
      ST_SIGN   = 6'b001000,
      ST_READ   = 6'b010000,
      ST_SEND   = 6'b100000
   } itoa_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic store_digit;
      logic store_sign;
      logic read;
      logic advance;
   } itoa_cmd_type;

   typedef struct packed {
      logic chunk_last;
      logic quot_zero;
      logic negative;
      logic last;
   } itoa_sts_type;

   function automatic logic [6:0] digit_char(input logic [5:0] digit, input logic upper);
      logic [6:0] base;
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (digit > DIGIT_MAX) begin
         return base + 7'(digit - RADIX_DEC);
      end
      return CHAR_ZERO + 7'(digit);
   endfunction

endpackage

// ===== src/itoa_req_if.sv =====
// ----------------------------------------------------------------------------
// itoa_req_if
// Request channel: one integer with its radix and formatting flags.
// ----------------------------------------------------------------------------
interface itoa_req_if #(
   parameter int VALUE_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic [5:0]                    radix;
   logic                          signed_mode;
   logic                          upper_case;

   modport source (output valid, value, radix, signed_mode, upper_case, input ready);
   modport sink   (input valid, value, radix, signed_mode, upper_case, output ready);
endinterface

// ===== src/itoa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// itoa_rsp_if
// Response channel: one ascii character per transaction, last marks the end.
// ----------------------------------------------------------------------------
interface itoa_rsp_if ();
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       last_char;

   modport source (output valid, out_char, last_char, input ready);
   modport sink   (input valid, out_char, last_char, output ready);
endinterface

// ===== src/itoa_datapath.sv =====
// ----------------------------------------------------------------------------
// itoa_datapath
// Chunked radix divider, digit store and character read-out.
// ----------------------------------------------------------------------------
module itoa_datapath
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  itoa_cmd_type           cmd,
   output itoa_sts_type           sts,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [5:0]             req_radix,
   input  logic                   req_signed_mode,
   input  logic                   req_upper_case,
   output logic [6:0]             rsp_char
);

   localparam int CHUNKS          = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int PAD_WIDTH       = CHUNKS * CHUNK_BITS;
   localparam int STORE_DEPTH     = VALUE_WIDTH + 1;
   localparam int ADDR_WIDTH      = $clog2(STORE_DEPTH);
   localparam int CNT_WIDTH       = $clog2(STORE_DEPTH + 1);
   localparam int CHUNK_CNT_WIDTH = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   logic [PAD_WIDTH-1:0]       div_ff, div_in;
   logic [5:0]                 rem_ff, rem_in;
   logic [5:0]                 radix_ff;
   logic                       upper_ff;
   logic                       neg_ff;
   logic [CHUNK_CNT_WIDTH-1:0] chunk_ff, chunk_in;
   logic [CNT_WIDTH-1:0]       cnt_ff, cnt_in;
   logic [ADDR_WIDTH-1:0]      rd_idx_ff, rd_idx_in;
   logic [6:0]                 rd_data_ff;
   logic [6:0]                 store_mem [STORE_DEPTH];

   logic [5:0]             radix_clamped;
   logic                   load_neg;
   logic [VALUE_WIDTH-1:0] load_mag;
   logic [CHUNK_BITS-1:0]  top_chunk;
   logic [CHUNK_BITS-1:0]  q_bits;
   logic [5:0]             part_rem;
   logic [6:0]             trial;
   logic [6:0]             wr_char;
   logic                   wr_en;

   always_comb begin
      priority if (req_radix < RADIX_MIN) begin
         radix_clamped = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         radix_clamped = RADIX_MAX;
      end else begin
         radix_clamped = req_radix;
      end
      load_neg = req_value[VALUE_WIDTH-1] & req_signed_mode & (radix_clamped == RADIX_DEC);
      load_mag = load_neg ? (~req_value + 1'b1) : req_value;
   end

   // restoring division of the top chunk by the radix, one bit per inner step
   always_comb begin
      top_chunk = div_ff[PAD_WIDTH-1 -: CHUNK_BITS];
      part_rem  = rem_ff;
      q_bits    = '0;
      trial     = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         trial = {part_rem, top_chunk[i]};
         if (trial >= {1'b0, radix_ff}) begin
            part_rem  = 6'(trial - {1'b0, radix_ff});
            q_bits[i] = 1'b1;
         end else begin
            part_rem  = trial[5:0];
         end
      end
   end

   always_comb begin
      div_in    = div_ff;
      rem_in    = rem_ff;
      chunk_in  = chunk_ff;
      cnt_in    = cnt_ff;
      rd_idx_in = rd_idx_ff;
      wr_en     = cmd.store_digit | cmd.store_sign;
      wr_char   = cmd.store_sign ? CHAR_MINUS : digit_char(rem_ff, upper_ff);
      if (cmd.load) begin
         div_in   = PAD_WIDTH'(load_mag);
         rem_in   = '0;
         chunk_in = '0;
         cnt_in   = '0;
      end
      if (cmd.step) begin
         div_in   = (div_ff << CHUNK_BITS) | PAD_WIDTH'(q_bits);
         rem_in   = part_rem;
         chunk_in = sts.chunk_last ? '0 : chunk_ff + 1'b1;
      end
      if (wr_en) begin
         rem_in    = '0;
         cnt_in    = cnt_ff + 1'b1;
         rd_idx_in = cnt_ff[ADDR_WIDTH-1:0];
      end
      if (cmd.advance) begin
         rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff  <= '0;
         cnt_ff    <= '0;
         rd_idx_ff <= '0;
      end else begin
         chunk_ff  <= chunk_in;
         cnt_ff    <= cnt_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      if (cmd.load) begin
         radix_ff <= radix_clamped;
         upper_ff <= req_upper_case;
         neg_ff   <= load_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[cnt_ff[ADDR_WIDTH-1:0]] <= wr_char;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

   assign sts.chunk_last = (chunk_ff == CHUNK_CNT_WIDTH'(CHUNKS - 1));
   assign sts.quot_zero  = (div_ff == '0);
   assign sts.negative   = neg_ff;
   assign sts.last       = (rd_idx_ff == '0);
   assign rsp_char       = rd_data_ff;

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.store_digit || cmd.store_sign) |-> (cnt_ff < CNT_WIDTH'(STORE_DEPTH)))
      else $error("digit store overflow");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (rem_ff < radix_ff))
      else $error("partial remainder not below radix");

endmodule

// ===== src/itoa_controller.sv =====
// ----------------------------------------------------------------------------
// itoa_controller
// Sequencer: accept, divide chunk by chunk, store digits, read them out.
// ----------------------------------------------------------------------------
module itoa_controller
   import itoa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output itoa_cmd_type cmd,
   input  itoa_sts_type sts
);

   itoa_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (sts.chunk_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store_digit = 1'b1;
            priority if (!sts.quot_zero) begin
               state_in = ST_DIVIDE;
            end else if (sts.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SIGN: begin
            cmd.store_sign = 1'b1;
            state_in       = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               if (sts.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);

   a_more_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE && !sts.quot_zero) |=> (state_ff == ST_DIVIDE))
      else $error("nonzero quotient did not continue division");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && sts.last) |=> req_ready)
      else $error("final character did not return to idle");

   a_read_then_send: assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> (rsp_valid && !req_ready))
      else $error("store read not followed by response");

endmodule

// ===== src/integer_to_ascii_radix_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core
// Converts one integer per request into ascii digits, most significant first.
// ----------------------------------------------------------------------------
// One request is taken at a time. For each digit the shared divider steps
// through all ceil(VALUE_WIDTH/8) chunks of the value (it retires eight
// quotient bits a cycle), then the remainder is written to the digit store
// as a character; a minus sign is then written as well for a negative signed
// decimal value. Each character is read out from the digit store (store read,
// then response), and the response is held while rsp is stalled. The request
// side is ready again once the last character of the previous number has
// been taken.
module integer_to_ascii_radix_core
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   itoa_req_if.sink   req_chan,
   itoa_rsp_if.source rsp_chan
);

   itoa_cmd_type cmd;
   itoa_sts_type sts;

   itoa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   itoa_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_value       (VALUE_WIDTH'(req_chan.value)),
      .req_radix       (req_chan.radix),
      .req_signed_mode (req_chan.signed_mode),
      .req_upper_case  (req_chan.upper_case),
      .rsp_char        (rsp_chan.out_char)
   );

   assign rsp_chan.last_char = sts.last;

endmodule
